>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define EAN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ean13 assertion failed");

// implication whose consequent is checked in the next cycle
`define EAN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ean13 assertion failed");

`endif

>>> rtl/ean13_pkg.sv
// types, code tables and helper functions for the ean-13 segment encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ean13_pkg;

  localparam int unsigned NumDigits = 12;
  localparam int unsigned NumSegs   = 15;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BADNIB   = 2'd2
  } status_e;

  typedef struct packed {
    logic [47:0] digits;
    logic [3:0]  chk;
    status_e     status;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } rd_t;

  localparam logic [6:0] GuardSide = 7'b0000101;
  localparam logic [6:0] GuardMid  = 7'b0001010;
  localparam logic [2:0] LenSide   = 3'd3;
  localparam logic [2:0] LenMid    = 3'd5;
  localparam logic [2:0] LenDigit  = 3'd7;

  localparam logic [3:0] SegStart = 4'd0;
  localparam logic [3:0] SegMid   = 4'd7;
  localparam logic [3:0] SegEnd   = 4'd14;

  // digit code in l, g or r set
  function automatic logic [6:0] code_l(input logic [3:0] d);
    logic [6:0] c;
    unique case (d)
      4'd0: c = 7'h0D;
      4'd1: c = 7'h19;
      4'd2: c = 7'h13;
      4'd3: c = 7'h3D;
      4'd4: c = 7'h23;
      4'd5: c = 7'h31;
      4'd6: c = 7'h2F;
      4'd7: c = 7'h3B;
      4'd8: c = 7'h37;
      4'd9: c = 7'h0B;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] code_g(input logic [3:0] d);
    logic [6:0] c;
    unique case (d)
      4'd0: c = 7'h27;
      4'd1: c = 7'h33;
      4'd2: c = 7'h1B;
      4'd3: c = 7'h21;
      4'd4: c = 7'h1D;
      4'd5: c = 7'h39;
      4'd6: c = 7'h05;
      4'd7: c = 7'h11;
      4'd8: c = 7'h09;
      4'd9: c = 7'h17;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] code_r(input logic [3:0] d);
    logic [6:0] c;
    unique case (d)
      4'd0: c = 7'h72;
      4'd1: c = 7'h66;
      4'd2: c = 7'h6C;
      4'd3: c = 7'h42;
      4'd4: c = 7'h5C;
      4'd5: c = 7'h4E;
      4'd6: c = 7'h50;
      4'd7: c = 7'h44;
      4'd8: c = 7'h48;
      4'd9: c = 7'h74;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // parity row of the first digit, msb is the first left digit, 1 selects g
  function automatic logic [5:0] parity_row(input logic [3:0] d);
    logic [5:0] p;
    unique case (d)
      4'd0: p = 6'b000000;
      4'd1: p = 6'b001011;
      4'd2: p = 6'b001101;
      4'd3: p = 6'b001110;
      4'd4: p = 6'b010011;
      4'd5: p = 6'b011001;
      4'd6: p = 6'b011100;
      4'd7: p = 6'b010101;
      4'd8: p = 6'b010110;
      4'd9: p = 6'b011010;
      default: p = 6'b000000;
    endcase
    return p;
  endfunction

  // check digit from the weighted sum, mod 10 by reciprocal multiply
  function automatic logic [3:0] check_of(input logic [7:0] sum);
    logic [15:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    prod = {8'd0, sum} * 16'd205;
    quo  = prod[15:11];
    rem  = sum - 8'({quo, 3'd0} + {2'd0, quo, 1'b0});
    return (rem[3:0] == 4'd0) ? 4'd0 : 4'(4'd10 - rem[3:0]);
  endfunction

endpackage

`default_nettype wire

>>> rtl/ean13_barcode_encoder.sv
// ean-13 segment encoder: a code in, fifteen segments or one error result out
// path: a code is registered in the front end and queued; each segment is registered in the back end
// throughput: one segment per cycle while m_axis_tready is high, so one code per fifteen segments (one on error),
//   set by the back end segment counter; the front end runs ahead into a 2-deep queue
// reset: rst_ni asynchronous active low clears all valid flags, pointers and counters
// depends on ean13_pkg, ean_front, ean_queue, ean_back
`timescale 1ns / 1ps
`default_nettype none

module ean13_barcode_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // digits_bcd[51:0], zero pad
  input  wire logic        s_axis_tuser,   // check_given
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // pattern[6:0], pattern_len, check_digit, status
  output      logic        m_axis_tlast
);
  import ean13_pkg::*;

  wr_t        wr;
  rd_t        rd;
  logic       full, pop;
  logic [6:0] pattern;
  logic [2:0] pattern_len;
  logic [3:0] check_digit;
  logic [1:0] status;

  ean_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .digits_bcd_i  (s_axis_tdata[51:0]),
    .check_given_i (s_axis_tuser),
    .q_full_i      (full),
    .wr_o          (wr)
  );

  ean_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .full_o (full),
    .rd_o   (rd),
    .pop_i  (pop)
  );

  ean_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_i          (rd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pattern_o     (pattern),
    .pattern_len_o (pattern_len),
    .check_digit_o (check_digit),
    .status_o      (status),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {status, check_digit, pattern_len, pattern};

endmodule

`default_nettype wire

>>> rtl/ean_front.sv
// front end: accepts codes, checks nibbles, forms the check digit and status
// depends on ean13_pkg
`timescale 1ns / 1ps
`default_nettype none

module ean_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [51:0]        digits_bcd_i,
  input  wire logic               check_given_i,
  input  wire logic               q_full_i,
  output      ean13_pkg::wr_t     wr_o
);
  import ean13_pkg::*;

  logic        v_q, v_d;
  logic [51:0] bcd_q;
  logic        verify_q;
  logic [7:0]  sum_q, sum_d;
  logic        bad_q, bad_d;
  logic        take, push;
  logic [3:0]  chk;

  assign push       = v_q && !q_full_i;
  assign in_ready_o = !v_q || !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  // weighted sum and nibble range check of the incoming code
  always_comb begin
    logic [3:0] d;
    sum_d = 8'd0;
    bad_d = 1'b0;
    for (int i = 0; i < NumDigits; i++) begin
      d = digits_bcd_i[51 - 4*i -: 4];
      sum_d = sum_d + ((i % 2 == 1) ? 8'({d, 1'b0} + {1'b0, d}) : {4'd0, d});
      if (d > 4'd9) bad_d = 1'b1;
    end
    if (check_given_i && digits_bcd_i[3:0] > 4'd9) bad_d = 1'b1;
  end

  always_comb begin
    v_d = v_q;
    if (take) v_d = 1'b1;
    else if (push) v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bcd_q    <= digits_bcd_i;
      verify_q <= check_given_i;
      sum_q    <= sum_d;
      bad_q    <= bad_d;
    end
  end

  assign chk = check_of(sum_q);

  always_comb begin
    wr_o.push        = push;
    wr_o.item.digits = bcd_q[51:4];
    wr_o.item.chk    = chk;
    priority if (bad_q) begin
      wr_o.item.status = ST_BADNIB;
      wr_o.item.chk    = 4'd0;
    end else if (verify_q && bcd_q[3:0] != chk) begin
      wr_o.item.status = ST_MISMATCH;
    end else begin
      wr_o.item.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ean_queue.sv
// short queue of classified codes between front and back
// depends on ean13_pkg
`timescale 1ns / 1ps
`default_nettype none

module ean_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ean13_pkg::wr_t  wr_i,
  output      logic            full_o,
  output      ean13_pkg::rd_t  rd_o,
  input  wire logic            pop_i
);
  import ean13_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_pop;

  assign full_o   = cnt_q == (PtrW+1)'(Depth);
  assign rd_o.valid = cnt_q != '0;
  assign rd_o.item  = mem_q[rp_q];
  assign do_pop   = pop_i && rd_o.valid;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (wr_i.push) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wp_q + 1'b1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rp_q + 1'b1);
    end
    if (wr_i.push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!wr_i.push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) mem_q[wp_q] <= wr_i.item;
  end

endmodule

`default_nettype wire

>>> rtl/ean_back.sv
// back end: steps through the fifteen segments of the head code, or gives one result for an error code
// depends on ean13_pkg
`timescale 1ns / 1ps
`default_nettype none

module ean_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ean13_pkg::rd_t  rd_i,
  output      logic            pop_o,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      logic [6:0]      pattern_o,
  output      logic [2:0]      pattern_len_o,
  output      logic [3:0]      check_digit_o,
  output      logic [1:0]      status_o,
  output      logic            last_o
);
  import ean13_pkg::*;

  logic [3:0] seg_q, seg_d;
  logic       ov_q, ov_d;
  logic [6:0] pat_q, pat_d;
  logic [2:0] len_q, len_d;
  logic [3:0] chk_q;
  status_e    st_q;
  logic       last_q, last_d;
  logic       load;
  logic [3:0] idx, dig, first;
  logic [5:0] prow;
  logic       gsel;

  assign load  = rd_i.valid && (!ov_q || out_ready_i);
  assign pop_o = load && last_d;

  assign first = rd_i.item.digits[47:44];
  assign prow  = parity_row(first);
  assign idx   = (seg_q < SegMid) ? seg_q : 4'(seg_q - 1'b1);
  assign dig   = (idx == 4'(NumDigits)) ? rd_i.item.chk
               : rd_i.item.digits[47 - 4*idx -: 4];
  assign gsel  = prow[3'(4'd6 - seg_q)];

  always_comb begin
    pat_d  = 7'd0;
    len_d  = 3'd0;
    last_d = 1'b0;
    if (rd_i.item.status != ST_OK) begin
      last_d = 1'b1;
    end else if (seg_q == SegStart) begin
      pat_d = GuardSide;
      len_d = LenSide;
    end else if (seg_q == SegMid) begin
      pat_d = GuardMid;
      len_d = LenMid;
    end else if (seg_q == SegEnd) begin
      pat_d  = GuardSide;
      len_d  = LenSide;
      last_d = 1'b1;
    end else if (seg_q < SegMid) begin
      pat_d = gsel ? code_g(dig) : code_l(dig);
      len_d = LenDigit;
    end else begin
      pat_d = code_r(dig);
      len_d = LenDigit;
    end
  end

  always_comb begin
    seg_d = seg_q;
    if (load) seg_d = last_d ? SegStart : 4'(seg_q + 1'b1);
    ov_d = ov_q;
    if (load) ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SegStart;
      ov_q  <= 1'b0;
    end else begin
      seg_q <= seg_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pat_q  <= pat_d;
      len_q  <= len_d;
      chk_q  <= rd_i.item.chk;
      st_q   <= rd_i.item.status;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign pattern_o     = pat_q;
  assign pattern_len_o = len_q;
  assign check_digit_o = chk_q;
  assign status_o      = st_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

>>> rtl/ean_checker.sv
// port-level checker for the ean-13 encoder, bound to the top level
// depends on ean13_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ean_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [55:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  import ean13_pkg::*;

  logic       unused;
  logic [2:0] m_len;
  logic [3:0] m_chk;
  logic [1:0] m_st;
  logic       m_len_ok;
  logic       m_stall;

  assign unused = s_axis_tvalid ^ s_axis_tready ^ s_axis_tuser ^ (^s_axis_tdata);

  assign m_len    = m_axis_tdata[9:7];
  assign m_chk    = m_axis_tdata[13:10];
  assign m_st     = m_axis_tdata[15:14];
  assign m_len_ok = m_len == LenSide || m_len == LenMid || m_len == LenDigit;
  assign m_stall  = m_axis_tvalid && !m_axis_tready;

  // error results stand alone and carry no modules
  `EAN_ASSERT_IMP(a_err_last, m_axis_tvalid && m_st != ST_OK, m_axis_tlast && m_len == 3'd0)
  // bad nibble result reports no check digit
  `EAN_ASSERT_IMP(a_bad_chk, m_axis_tvalid && m_st == ST_BADNIB, m_chk == 4'd0)
  // a good segment has a guard or digit length
  `EAN_ASSERT_IMP(a_ok_len, m_axis_tvalid && m_st == ST_OK, m_len_ok)
  // stalled transfer holds
  `EAN_ASSERT_NXT(a_hold, m_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind ean13_barcode_encoder ean_checker u_checker (.*);

`default_nettype wire

>>> tb/ean13_barcode_encoder_test.sv
// self-checking testbench for the ean-13 segment encoder: directed codes, then random codes
// with random idle bursts on both stream sides, checked against a built-in segment predictor
// depends on ean13_pkg and ean13_barcode_encoder
`timescale 1ns / 1ps

module ean13_barcode_encoder_test;
  import ean13_pkg::*;

  localparam int unsigned RandomCodes = 410;
  localparam int unsigned QuietCodes  = 60;

  // digit d sits at bits [7*d +: 7], parity row of first digit d at [6*d +: 6]
  localparam logic [69:0] LCodes = {7'h0B, 7'h37, 7'h3B, 7'h2F, 7'h31,
                                    7'h23, 7'h3D, 7'h13, 7'h19, 7'h0D};
  localparam logic [69:0] GCodes = {7'h17, 7'h09, 7'h11, 7'h05, 7'h39,
                                    7'h1D, 7'h21, 7'h1B, 7'h33, 7'h27};
  localparam logic [69:0] RCodes = {7'h74, 7'h48, 7'h44, 7'h50, 7'h4E,
                                    7'h5C, 7'h42, 7'h6C, 7'h66, 7'h72};
  localparam logic [59:0] ParityRows = {6'b011010, 6'b010110, 6'b010101, 6'b011100,
                                        6'b011001, 6'b010011, 6'b001110, 6'b001101,
                                        6'b001011, 6'b000000};

  typedef struct {
    logic [6:0] pattern;
    logic [2:0] len;
    logic [3:0] chk;
    status_e    status;
    logic       last;
  } segment_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // digits_bcd[51:0], zero pad
  logic        s_axis_tuser = 1'b0; // check_given
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // pattern[6:0], pattern_len, check_digit, status
  logic        m_axis_tlast;

  logic        quiet = 1'b0;
  int unsigned stall_left = 0;

  ean13_barcode_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // weighted 1,3 sum of the first twelve digits, folded to a check digit
  function automatic logic [3:0] weighted_check(input logic [51:0] bcd);
    int unsigned total = 0;
    for (int i = 0; i < 12; i++) begin
      total += bcd[4*(12-i) +: 4] * ((i % 2 == 1) ? 3 : 1);
    end
    return 4'((10 - total % 10) % 10);
  endfunction

  function automatic logic [51:0] random_digits();
    logic [51:0] v;
    for (int i = 0; i < 13; i++) begin
      v[4*i +: 4] = 4'($urandom_range(9));
    end
    return v;
  endfunction

  function automatic logic [51:0] with_check(input logic [51:0] bcd);
    return {bcd[51:4], weighted_check(bcd)};
  endfunction

  class segment_scoreboard;
    segment_t    expected_q[$];
    int unsigned fail_count = 0;
    int unsigned shown = 0;

    function void push_segment(logic [6:0] pattern, logic [2:0] len, logic [3:0] chk,
                               status_e status, logic last);
      segment_t s;
      s.pattern = pattern;
      s.len     = len;
      s.chk     = chk;
      s.status  = status;
      s.last    = last;
      expected_q.push_back(s);
    endfunction

    // predicts the segments caused by one accepted code
    function void note_code(input logic [51:0] bcd, input logic given);
      logic [3:0] dig [13];
      logic [3:0] chk;
      logic [5:0] par;
      logic       bad;
      bad = 1'b0;
      for (int i = 0; i < 13; i++) dig[i] = bcd[4*(12-i) +: 4];
      for (int i = 0; i < 12; i++) if (dig[i] > 4'd9) bad = 1'b1;
      if (given && dig[12] > 4'd9) bad = 1'b1;
      if (bad) begin
        push_segment(7'd0, 3'd0, 4'd0, ST_BADNIB, 1'b1);
        return;
      end
      chk = weighted_check(bcd);
      if (given && dig[12] != chk) begin
        push_segment(7'd0, 3'd0, chk, ST_MISMATCH, 1'b1);
        return;
      end
      dig[12] = chk;
      par = ParityRows[dig[0]*6 +: 6];
      push_segment(GuardSide, LenSide, chk, ST_OK, 1'b0);
      for (int i = 0; i < 6; i++) begin
        push_segment(par[5-i] ? GCodes[dig[1+i]*7 +: 7] : LCodes[dig[1+i]*7 +: 7],
                     LenDigit, chk, ST_OK, 1'b0);
      end
      push_segment(GuardMid, LenMid, chk, ST_OK, 1'b0);
      for (int i = 0; i < 6; i++) begin
        push_segment(RCodes[dig[7+i]*7 +: 7], LenDigit, chk, ST_OK, 1'b0);
      end
      push_segment(GuardSide, LenSide, chk, ST_OK, 1'b1);
    endfunction

    function void check_segment(input logic [15:0] data, input logic tlast);
      segment_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (shown < 10) begin
          $display("unexpected segment: data %h last %b", data, tlast);
          shown++;
        end
        return;
      end
      want = expected_q.pop_front();
      if (data[6:0] !== want.pattern || data[9:7] !== want.len ||
          data[13:10] !== want.chk || data[15:14] !== want.status || tlast !== want.last) begin
        fail_count++;
        if (shown < 10) begin
          $display("segment mismatch: expected pat %h len %0d chk %0d st %0d last %b",
                   want.pattern, want.len, want.chk, want.status, want.last);
          $display("                  got      pat %h len %0d chk %0d st %0d last %b",
                   data[6:0], data[9:7], data[13:10], data[15:14], tlast);
          shown++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  segment_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  // receiver side: random stall bursts, none in the quiet tail
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_segment(m_axis_tdata, m_axis_tlast);
  end

  // one code transfer, with an optional idle burst ahead of it
  task automatic send_code(input logic [51:0] bcd, input logic given);
    int unsigned gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'd0, bcd};
    s_axis_tuser  <= given;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_code(bcd, given);
  endtask

  task automatic send_random_code();
    logic [51:0] bcd;
    logic [3:0]  chk;
    int unsigned pick;
    int unsigned pos;
    pick = $urandom_range(99);
    bcd  = with_check(random_digits());
    if (pick < 50) begin
      if ($urandom_range(1) == 0) begin
        send_code(bcd, 1'b1);
      end else begin
        bcd[3:0] = 4'($urandom_range(15));
        send_code(bcd, 1'b0);
      end
    end else if (pick < 65) begin
      chk = bcd[3:0];
      bcd[3:0] = 4'((chk + $urandom_range(1, 9)) % 10);
      send_code(bcd, 1'b1);
    end else if (pick < 80) begin
      pos = $urandom_range(12);
      bcd[4*pos +: 4] = 4'($urandom_range(10, 15));
      send_code(bcd, 1'($urandom_range(1)));
    end else begin
      bcd = {20'($urandom), 32'($urandom)};
      send_code(bcd, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [51:0] bcd;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero remainder, all nines, then every first digit for each parity row
    send_code(52'h0, 1'b1);
    send_code(with_check(52'h9999999999999), 1'b1);
    for (int d = 0; d < 10; d++) begin
      bcd = random_digits();
      bcd[51:48] = 4'(d);
      send_code(with_check(bcd), 1'b1);
    end
    send_code(52'h4006381333931, 1'b1);
    send_code(52'h4006381333932, 1'b1);
    // check nibble above nine is ignored when not given, rejected when given
    send_code(52'h400638133393F, 1'b0);
    send_code(52'h400638133393F, 1'b1);
    send_code(52'hA006381333931, 1'b1);
    // bad nibble wins over a mismatch
    send_code(52'h40063813339F2, 1'b1);
    send_code(52'hFFFFFFFFFFFFF, 1'b0);
    send_code(52'hFFFFFFFFFFFFF, 1'b1);

    for (int n = 0; n < RandomCodes; n++) begin
      if (n == RandomCodes - QuietCodes) quiet <= 1'b1;
      send_random_code();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ean13_pkg.sv
rtl/ean_front.sv
rtl/ean_queue.sv
rtl/ean_back.sv
rtl/ean13_barcode_encoder.sv
rtl/ean_checker.sv
tb/ean13_barcode_encoder_test.sv
